[src/ook_switch_command_encoder_assert.svh]
// assertion macros for the ook switch command encoder
// needs clk and rst_n in the scope of the module that uses them
`ifndef OOK_SWITCH_COMMAND_ENCODER_ASSERT_SVH
`define OOK_SWITCH_COMMAND_ENCODER_ASSERT_SVH

// same-cycle implication, held off during reset
`define OOKSCE_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ooksce assertion failed");

// next-cycle implication, held off during reset
`define OOKSCE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ooksce assertion failed");

`endif

[src/ooksce_pkg.sv]
// shared types and constants for the ook switch command encoder
// no dependencies
`timescale 1ns / 1ps

package ooksce_pkg;

    // item operation codes
    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    // reset value of the time unit register
    localparam logic [15:0] BIT_TICKS_RESET = 16'd350;

    // frames per transmission
    localparam int REPEATS_DEFAULT = 4;

    // bit index of the sync pulse, after the twelve data bits
    localparam logic [3:0] SYNC_INDEX = 4'd12;

    // result of one beat
    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic finished;
    } res_t;

    // waveform engine status for the top level
    typedef struct packed {
        logic active;
    } wave_stat_t;

endpackage

[src/ooksce_wave.sv]
// waveform engine: frame latch, phase counters and pin level
// depends on ooksce_pkg
`timescale 1ns / 1ps

module ooksce_wave #(
    parameter int REPEATS = ooksce_pkg::REPEATS_DEFAULT
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    step,
    input  logic                    op,
    input  logic [7:0]              prefix,
    input  logic [3:0]              command,
    input  logic [15:0]             bit_ticks,
    output ooksce_pkg::res_t        res,
    output ooksce_pkg::wave_stat_t  stat
);

    localparam int RC_W = (REPEATS > 1) ? $clog2(REPEATS) : 1;
    localparam logic [RC_W-1:0] RC_LAST = RC_W'(REPEATS - 1);

    logic [11:0]     frame_bits_reg,   frame_bits_next;
    logic [RC_W-1:0] repeat_count_reg, repeat_count_next;
    logic [3:0]      bit_index_reg,    bit_index_next;
    logic            pulse_half_reg,   pulse_half_next;
    logic            high_phase_reg,   high_phase_next;
    logic [20:0]     tick_count_reg,   tick_count_next;
    logic            active_reg,       active_next;

    logic [15:0] unit;
    logic [17:0] unit3;
    logic [20:0] unit31;
    logic        is_sync;
    logic [3:0]  sel;
    logic        cur_bit;
    logic [20:0] phase_len;
    logic [21:0] tick_inc;
    logic        phase_end;

    // reverse bit order inside each nibble
    function automatic logic [7:0] nibble_reverse(input logic [7:0] b);
        logic [7:0] r;
        r = {b[0], b[1], b[2], b[3], b[4], b[5], b[6], b[7]};
        return {r[3:0], r[7:4]};
    endfunction

    // phase length in ticks
    always_comb
    begin
        unit      = (bit_ticks == 16'd0) ? 16'd1 : bit_ticks;
        unit3     = {1'b0, unit, 1'b0} + {2'b00, unit};
        unit31    = {unit, 5'b00000} - {5'b00000, unit};
        is_sync   = (bit_index_reg >= ooksce_pkg::SYNC_INDEX);
        sel       = 4'd11 - bit_index_reg;
        cur_bit   = is_sync ? 1'b0 : frame_bits_reg[sel];
        if (is_sync)
            phase_len = high_phase_reg ? {5'b00000, unit} : unit31;
        else if (pulse_half_reg && cur_bit)
            phase_len = high_phase_reg ? {3'b000, unit3} : {5'b00000, unit};
        else
            phase_len = high_phase_reg ? {5'b00000, unit} : {3'b000, unit3};
        tick_inc  = {1'b0, tick_count_reg} + 22'd1;
        phase_end = (tick_inc >= {1'b0, phase_len});
    end

    // next state and result
    always_comb
    begin
        frame_bits_next   = frame_bits_reg;
        repeat_count_next = repeat_count_reg;
        bit_index_next    = bit_index_reg;
        pulse_half_next   = pulse_half_reg;
        high_phase_next   = high_phase_reg;
        tick_count_next   = tick_count_reg;
        active_next       = active_reg;
        res.pin_level     = 1'b0;
        res.busy_res      = 1'b0;
        res.finished      = 1'b0;
        if (op == ooksce_pkg::OP_START)
        begin
            res.busy_res = 1'b1;
            if (!active_reg)
            begin
                frame_bits_next   = {nibble_reverse(prefix), command};
                repeat_count_next = '0;
                bit_index_next    = 4'd0;
                pulse_half_next   = 1'b0;
                high_phase_next   = 1'b1;
                tick_count_next   = 21'd0;
                active_next       = 1'b1;
            end
            else
            begin
                res.pin_level = high_phase_reg;
            end
        end
        else if (active_reg)
        begin
            res.pin_level = high_phase_reg;
            res.busy_res  = 1'b1;
            if (!phase_end)
            begin
                tick_count_next = tick_inc[20:0];
            end
            else
            begin
                tick_count_next = 21'd0;
                if (high_phase_reg)
                begin
                    high_phase_next = 1'b0;
                end
                else
                begin
                    high_phase_next = 1'b1;
                    if (is_sync)
                    begin
                        bit_index_next  = 4'd0;
                        pulse_half_next = 1'b0;
                        if (repeat_count_reg == RC_LAST)
                        begin
                            // last frame done, back to idle
                            active_next       = 1'b0;
                            repeat_count_next = '0;
                            high_phase_next   = 1'b0;
                            res.finished      = 1'b1;
                        end
                        else
                        begin
                            repeat_count_next = repeat_count_reg + RC_W'(1);
                        end
                    end
                    else if (!pulse_half_reg)
                    begin
                        pulse_half_next = 1'b1;
                    end
                    else
                    begin
                        pulse_half_next = 1'b0;
                        bit_index_next  = bit_index_reg + 4'd1;
                    end
                end
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_bits_reg   <= '0;
            repeat_count_reg <= '0;
            bit_index_reg    <= '0;
            pulse_half_reg   <= 1'b0;
            high_phase_reg   <= 1'b0;
            tick_count_reg   <= '0;
            active_reg       <= 1'b0;
        end
        else if (step)
        begin
            frame_bits_reg   <= frame_bits_next;
            repeat_count_reg <= repeat_count_next;
            bit_index_reg    <= bit_index_next;
            pulse_half_reg   <= pulse_half_next;
            high_phase_reg   <= high_phase_next;
            tick_count_reg   <= tick_count_next;
            active_reg       <= active_next;
        end
    end

    assign stat.active = active_reg;

endmodule

[src/ook_switch_command_encoder.sv]
// top level of the ook switch command encoder
// depends on ooksce_pkg, ooksce_wave and ook_switch_command_encoder_assert.svh
//
//  channel   handshake             payload
//  in        in_valid / in_stall   op, prefix, command
//  out       out_valid / out_stall pin_level, busy_res, finished
//  cfg       cfg_we                cfg_wdata (bit_ticks)
//
// the waveform state steps as a beat is accepted and the
// result lands in the output register on the same edge.
// one beat in and one out per cycle while out_stall is low.
// in_stall is high only while the output register holds a beat that is stalled.
// reset leaves the block idle with bit_ticks at 350.
`timescale 1ns / 1ps
`include "ook_switch_command_encoder_assert.svh"

module ook_switch_command_encoder #(
    parameter int REPEATS = ooksce_pkg::REPEATS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        op,
    input  logic [7:0]  prefix,
    input  logic [3:0]  command,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        pin_level,
    output logic        busy_res,
    output logic        finished,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);

    logic [15:0]            bit_ticks_reg;
    logic                   out_valid_reg, out_valid_next;
    ooksce_pkg::res_t       out_res_reg;
    ooksce_pkg::res_t       res_next;
    ooksce_pkg::wave_stat_t stat;
    logic                   in_acc;

    // accept when the output register is free or draining
    assign in_stall = out_valid_reg & out_stall;
    assign in_acc   = in_valid & ~in_stall;

    // time unit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_ticks_reg <= ooksce_pkg::BIT_TICKS_RESET;
        else if (cfg_we)
            bit_ticks_reg <= cfg_wdata;
    end

    // waveform engine
    ooksce_wave #(
        .REPEATS (REPEATS)
    ) u_wave (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_acc),
        .op        (op),
        .prefix    (prefix),
        .command   (command),
        .bit_ticks (bit_ticks_reg),
        .res       (res_next),
        .stat      (stat)
    );

    // output register
    always_comb
    begin
        if (in_acc)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            out_res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign pin_level = out_res_reg.pin_level;
    assign busy_res  = out_res_reg.busy_res;
    assign finished  = out_res_reg.finished;

    // checks
    `OOKSCE_ASSERT_NEXT(a_start_goes_busy,
        in_acc && op == ooksce_pkg::OP_START, stat.active)
    `OOKSCE_ASSERT_NEXT(a_finish_goes_idle,
        in_acc && res_next.finished, !stat.active && out_valid && finished)
    `OOKSCE_ASSERT_IMPLIES(a_level_only_when_busy,
        out_valid && (pin_level || finished), busy_res)

endmodule

[sim/tb_ook_switch_command_encoder.sv]
// self-checking testbench for the ook switch command encoder: random and directed beats,
// carrier level predicted per tick and compared against every result beat
// depends on ooksce_pkg and ook_switch_command_encoder
`timescale 1ns / 1ps

module tb_ook_switch_command_encoder;

    localparam int STALL_LIMIT = 4000;
    // every bit and the sync pulse take eight and thirty-two units, four frames per run
    localparam int UNITS_PER_RUN = 128 * ooksce_pkg::REPEATS_DEFAULT;

    typedef enum int {
        IDLE_NONE = 0,
        IDLE_SEND = 1,
        IDLE_RECV = 2,
        IDLE_BOTH = 3
    } idle_mode_t;

    typedef struct {
        logic       op;
        logic [7:0] prefix;
        logic [3:0] command;
        idle_mode_t mode;
        bit         hold;
    } stim_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        op = ooksce_pkg::OP_TICK;
    logic [7:0]  prefix = 8'd0;
    logic [3:0]  command = 4'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        pin_level;
    logic        busy_res;
    logic        finished;
    logic        cfg_we = 1'b0;
    logic [15:0] cfg_wdata = 16'd0;

    // stimulus backlog and predicted results
    stim_beat_t        beat_backlog[$];
    ooksce_pkg::res_t  pin_due[$];
    logic              in_taken = 1'b0;
    idle_mode_t        cur_mode = IDLE_NONE;

    // planning of well-formed runs while the backlog is filled
    int plan_left = 0;
    int plan_unit = int'(ooksce_pkg::BIT_TICKS_RESET);
    int traffic_count = 0;

    // predictor state
    logic [15:0] unit_ticks = ooksce_pkg::BIT_TICKS_RESET;
    logic [11:0] wave_frame = 12'd0;
    int          wave_rep = 0;
    logic [3:0]  wave_bit = 4'd0;
    logic        wave_half = 1'b0;
    logic        wave_high = 1'b0;
    logic [20:0] wave_cnt = 21'd0;
    logic        wave_on = 1'b0;

    // run statistics
    int mismatches = 0;
    int results_checked = 0;
    int starts_sent = 0;
    int ticks_sent = 0;
    int runs_done = 0;
    int quiet_cycles = 0;

    ook_switch_command_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .prefix    (prefix),
        .command   (command),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pin_level (pin_level),
        .busy_res  (busy_res),
        .finished  (finished),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #6 clk = ~clk;

    // carrier level and status for one accepted beat, advancing the waveform
    function automatic ooksce_pkg::res_t predict_pin(logic b_op, logic [7:0] b_pfx,
                                                     logic [3:0] b_cmd);
        ooksce_pkg::res_t r;
        logic [20:0]      unit;
        logic [20:0]      span;
        logic             cur_bit;
        r = '0;
        unit = (unit_ticks == 16'd0) ? 21'd1 : {5'd0, unit_ticks};
        if (b_op == ooksce_pkg::OP_START)
        begin
            r.busy_res = 1'b1;
            if (wave_on)
            begin
                r.pin_level = wave_high;
            end
            else
            begin
                // prefix bits mirrored inside each nibble, command below
                for (int k = 0; k < 4; k++)
                begin
                    wave_frame[7 - k] = b_pfx[k];
                    wave_frame[11 - k] = b_pfx[4 + k];
                end
                wave_frame[3:0] = b_cmd;
                wave_rep = 0;
                wave_bit = 4'd0;
                wave_half = 1'b0;
                wave_high = 1'b1;
                wave_cnt = 21'd0;
                wave_on = 1'b1;
            end
        end
        else if (wave_on)
        begin
            r.pin_level = wave_high;
            r.busy_res = 1'b1;
            cur_bit = (wave_bit < ooksce_pkg::SYNC_INDEX) ? wave_frame[11 - wave_bit] : 1'b0;
            // length of the current phase in ticks
            if (wave_bit >= ooksce_pkg::SYNC_INDEX)
                span = wave_high ? unit : 21'(31 * unit);
            else if (wave_half && cur_bit)
                span = wave_high ? 21'(3 * unit) : unit;
            else
                span = wave_high ? unit : 21'(3 * unit);
            if (wave_cnt + 1 >= span)
            begin
                wave_cnt = 21'd0;
                if (wave_high)
                begin
                    wave_high = 1'b0;
                end
                else
                begin
                    wave_high = 1'b1;
                    if (wave_bit >= ooksce_pkg::SYNC_INDEX)
                    begin
                        wave_bit = 4'd0;
                        wave_half = 1'b0;
                        if (wave_rep + 1 >= ooksce_pkg::REPEATS_DEFAULT)
                        begin
                            // last frame done, back to idle
                            wave_on = 1'b0;
                            wave_rep = 0;
                            wave_high = 1'b0;
                            r.finished = 1'b1;
                        end
                        else
                        begin
                            wave_rep++;
                        end
                    end
                    else if (!wave_half)
                    begin
                        wave_half = 1'b1;
                    end
                    else
                    begin
                        wave_half = 1'b0;
                        wave_bit++;
                    end
                end
            end
            else
            begin
                wave_cnt++;
            end
        end
        return r;
    endfunction

    // queue one beat and track the planned run length
    task automatic push_beat(logic b_op, logic [7:0] b_pfx, logic [3:0] b_cmd,
                             idle_mode_t b_mode, bit b_hold);
        stim_beat_t nb;
        nb.op = b_op;
        nb.prefix = b_pfx;
        nb.command = b_cmd;
        nb.mode = b_mode;
        nb.hold = b_hold;
        beat_backlog.push_back(nb);
        if (b_op == ooksce_pkg::OP_START)
        begin
            if (plan_left == 0)
                plan_left = UNITS_PER_RUN * plan_unit;
        end
        else if (plan_left != 0)
        begin
            plan_left--;
        end
    endtask

    // well-formed runs with random content, spurious starts and idle ticks as noise
    task automatic add_traffic(int runs, int cap);
        int         ended;
        idle_mode_t mode;
        bit         hold;
        ended = 0;
        for (int made = 0; made < cap; made++)
        begin
            mode = idle_mode_t'((traffic_count / 64) % 4);
            hold = ($urandom_range(0, 149) == 0);
            traffic_count++;
            if (plan_left == 0)
            begin
                if (ended >= runs)
                    break;
                if ($urandom_range(0, 3) == 0)
                    push_beat(ooksce_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)), mode, hold);
                else
                    push_beat(ooksce_pkg::OP_START, 8'($urandom_range(0, 255)),
                              4'($urandom_range(0, 15)), mode, hold);
            end
            else if ($urandom_range(0, 39) == 0)
            begin
                push_beat(ooksce_pkg::OP_START, 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)), mode, hold);
            end
            else
            begin
                push_beat(ooksce_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                          4'($urandom_range(0, 15)), mode, hold);
                if (plan_left == 0)
                    ended++;
            end
        end
    endtask

    // until every queued beat is in and every predicted result is out
    task automatic wait_drained();
        while (beat_backlog.size() != 0 || in_valid || pin_due.size() != 0)
            @(posedge clk);
    endtask

    // time unit register write, only with the block idle
    task automatic set_unit(logic [15:0] value);
        wait_drained();
        repeat (2) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        plan_unit = (value == 16'd0) ? 1 : int'(value);
    endtask

    // sender and receiver, both moving on the falling edge
    always @(negedge clk)
    begin : driver
        stim_beat_t nb;
        int         send_pct;
        int         recv_pct;
        if (rst_n)
        begin
            recv_pct = (cur_mode == IDLE_RECV) ? 60 : (cur_mode == IDLE_BOTH) ? 9 : 0;
            out_stall <= ($urandom_range(0, 99) < recv_pct);
            // a stalled beat stays as it is
            if (!in_valid || in_taken)
            begin
                send_pct = 0;
                if (beat_backlog.size() != 0)
                    send_pct = (beat_backlog[0].mode == IDLE_SEND) ? 60 :
                               (beat_backlog[0].mode == IDLE_BOTH) ? 9 : 0;
                if (beat_backlog.size() == 0 || (beat_backlog[0].hold && pin_due.size() != 0)
                    || $urandom_range(0, 99) < send_pct)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    nb = beat_backlog.pop_front();
                    cur_mode = nb.mode;
                    in_valid <= 1'b1;
                    op <= nb.op;
                    prefix <= nb.prefix;
                    command <= nb.command;
                end
            end
        end
    end

    // result checking, prediction and watchdog on the rising edge
    always @(posedge clk)
    begin : monitor
        ooksce_pkg::res_t seen;
        ooksce_pkg::res_t want;
        logic             moved;
        if (rst_n)
        begin
            moved = 1'b0;
            // result beat against the oldest prediction
            if (out_valid && !out_stall)
            begin
                moved = 1'b1;
                seen = {pin_level, busy_res, finished};
                if (pin_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("%0t: result beat with nothing predicted (pin %b busy %b fin %b)",
                                 $time, seen.pin_level, seen.busy_res, seen.finished);
                    mismatches++;
                end
                else
                begin
                    want = pin_due.pop_front();
                    if (seen.pin_level !== want.pin_level || seen.busy_res !== want.busy_res
                        || seen.finished !== want.finished)
                    begin
                        if (mismatches < 10)
                            $display("%0t: result %0d expected pin %b busy %b fin %b, got %b %b %b",
                                     $time, results_checked, want.pin_level, want.busy_res,
                                     want.finished, seen.pin_level, seen.busy_res, seen.finished);
                        mismatches++;
                    end
                    results_checked++;
                end
            end
            // prediction for the accepted input beat
            if (in_valid && !in_stall)
            begin
                moved = 1'b1;
                want = predict_pin(op, prefix, command);
                pin_due.push_back(want);
                if (op == ooksce_pkg::OP_START)
                    starts_sent++;
                else
                    ticks_sent++;
                if (want.finished)
                    runs_done++;
            end
            if (cfg_we)
                unit_ticks = cfg_wdata;
            in_taken <= in_valid && !in_stall;
            // watchdog on cycles without any beat
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("[ook_switch_command_encoder] ERROR");
                $finish;
            end
        end
    end

    // reset, then phases of stimulus at several time unit settings
    initial
    begin : stimulus
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // idle ticks under the reset time unit, fields at their extremes and in alternating patterns
        push_beat(ooksce_pkg::OP_TICK, 8'hFF, 4'hF, IDLE_NONE, 1'b0);
        push_beat(ooksce_pkg::OP_TICK, 8'h00, 4'h0, IDLE_NONE, 1'b0);
        push_beat(ooksce_pkg::OP_TICK, 8'hA5, 4'h5, IDLE_NONE, 1'b0);
        push_beat(ooksce_pkg::OP_TICK, 8'h5A, 4'hA, IDLE_NONE, 1'b0);

        // zero time unit behaves as one; start, ignored starts, sender pause
        set_unit(16'd0);
        push_beat(ooksce_pkg::OP_START, 8'hFF, 4'hF, IDLE_NONE, 1'b0);
        push_beat(ooksce_pkg::OP_START, 8'h00, 4'h0, IDLE_NONE, 1'b0);
        push_beat(ooksce_pkg::OP_TICK, 8'h00, 4'h0, IDLE_NONE, 1'b0);
        push_beat(ooksce_pkg::OP_TICK, 8'hFF, 4'hF, IDLE_NONE, 1'b0);
        push_beat(ooksce_pkg::OP_START, 8'hA5, 4'hC, IDLE_NONE, 1'b1);
        for (int k = 0; k < 4; k++)
            push_beat(ooksce_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), IDLE_NONE, 1'b0);
        add_traffic(1, 2000);

        // largest time unit, idle ticks only
        set_unit(16'hFFFF);
        for (int k = 0; k < 8; k++)
            push_beat(ooksce_pkg::OP_TICK, 8'($urandom_range(0, 255)),
                      4'($urandom_range(0, 15)), IDLE_BOTH, 1'b0);

        // smallest time unit, one full random run
        set_unit(16'd1);
        add_traffic(1, 2000);

        // three ticks per unit, stopped part way through a run
        set_unit(16'd3);
        add_traffic(1, 140);

        wait_drained();
        repeat (4) @(posedge clk);
        mismatches += pin_due.size();
        $display("covered %0d starts and %0d ticks over five time unit settings",
                 starts_sent, ticks_sent);
        $display("%0d results checked, %0d runs completed, %0d mismatches",
                 results_checked, runs_done, mismatches);
        if (mismatches == 0)
            $display("[ook_switch_command_encoder] OK");
        else
            $display("[ook_switch_command_encoder] ERROR");
        $finish;
    end

endmodule
